// ----- design/pbt_pkg.sv -----
// Shared constants and types of the page backing tracker.
package pbt_pkg;

   localparam int DEFAULT_MAX_PAGES = 4096;

   localparam logic [2:0] ACT_MAP         = 3'd0;
   localparam logic [2:0] ACT_UNMAP       = 3'd1;
   localparam logic [2:0] ACT_RELEASE     = 3'd2;
   localparam logic [2:0] ACT_ALL_MAPPED  = 3'd3;
   localparam logic [2:0] ACT_ALL_UNMAPPED = 3'd4;
   localparam logic [2:0] ACT_RELEASABLE  = 3'd5;
   localparam logic [2:0] ACT_VALIDATE    = 3'd6;
   localparam logic [2:0] ACT_READ_TOTAL  = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_CONFLICT = 2'd2;

   localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
   localparam logic [1:0] CFG_REGION_PAGES = 2'd1;
   localparam logic [1:0] CFG_PAGE_SHIFT   = 2'd2;
   localparam logic [1:0] CFG_CONFIGURED   = 2'd3;

   localparam logic [5:0] PAGE_SHIFT_RESET = 6'd21;

   typedef struct packed {
      logic valid;
      logic ok;
   } chk_status_type;

endpackage

// ----- design/pbt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/pbt_range_check.sv -----
// Two-stage range check: region bounds, alignment, start page and page count.
module pbt_range_check #(
   parameter int MAX_PAGES = pbt_pkg::DEFAULT_MAX_PAGES,
   parameter int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
   parameter int CW = $clog2(MAX_PAGES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic                  overlap,
   input  logic [63:0]           range_address,
   input  logic [63:0]           range_bytes,
   input  logic [63:0]           region_base,
   input  logic [12:0]           region_pages,
   input  logic [5:0]            page_shift,
   input  logic                  configured,
   output pbt_pkg::chk_status_type result,
   output logic [IW-1:0]         start_page,
   output logic [CW-1:0]         page_count
);
   import pbt_pkg::*;

   logic [CW-1:0]    pages;
   logic [63+CW:0]   bytes_wide;
   logic [64:0]      end_sum;
   logic [64:0]      va_end;
   logic [63:0]      mask;

   logic             s1_valid_ff, s1_valid_in;
   logic             overlap_ff;
   logic [63:0]      size_ff;
   logic             end_ok_ff;
   logic [63:0]      end_addr_ff;
   logic             below_ff;
   logic [64:0]      va_end_ff;
   logic [63:0]      diff_ff;
   logic [63:0]      endoff_ff;

   logic             in_region;
   logic             aligned;
   logic [CW-1:0]    start_full;
   logic [CW-1:0]    limit_page;
   logic [CW-1:0]    count_in;

   logic             valid_ff, ok_ff;
   logic [IW-1:0]    start_ff;
   logic [CW-1:0]    count_ff;

   assign pages = (32'(region_pages) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(region_pages);
   assign bytes_wide = (64 + CW)'(pages) << page_shift;
   assign end_sum = {1'b0, region_base} + {1'b0, bytes_wide[63:0]};
   assign va_end = {1'b0, range_address} + {1'b0, range_bytes};
   assign mask = (64'd1 << page_shift) - 64'd1;
   assign s1_valid_in = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         valid_ff    <= s1_valid_ff;
      end
   end

   // Stage one: region end, range end and offsets
   always_ff @(posedge clock) begin
      if (go) begin
         overlap_ff  <= overlap;
         size_ff     <= range_bytes;
         end_ok_ff   <= ~(|bytes_wide[63+CW:64]) & ~end_sum[64];
         end_addr_ff <= end_sum[63:0];
         below_ff    <= range_address < region_base;
         va_end_ff   <= va_end;
         diff_ff     <= range_address - region_base;
         endoff_ff   <= va_end[63:0] - region_base;
      end
   end

   // Stage two: containment, alignment and page arithmetic
   assign in_region = configured && (size_ff != 64'd0) && end_ok_ff && !below_ff &&
                      !va_end_ff[64] && (va_end_ff[63:0] <= end_addr_ff);
   assign aligned = ((size_ff & mask) == 64'd0) && ((diff_ff & mask) == 64'd0);
   assign start_full = CW'(diff_ff >> page_shift);
   assign limit_page = CW'(endoff_ff >> page_shift) + CW'((endoff_ff & mask) != 64'd0);
   assign count_in = overlap_ff ? (limit_page - start_full) : CW'(size_ff >> page_shift);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ok_ff    <= in_region && (overlap_ff || aligned);
         start_ff <= IW'(start_full);
         count_ff <= count_in;
      end
   end

   assign result.valid = valid_ff;
   assign result.ok    = ok_ff;
   assign start_page   = start_ff;
   assign page_count   = count_ff;
endmodule

// ----- design/page_backing_tracker_top.sv -----
// Top level of the page backing tracker: control sequencer, page table and registers.
// Each request is taken in the idle state, then passes the range check, then walks its
// pages (reading each page table entry from its RAM, then modifying and writing it back),
// then posts the response word once the output register is free. Read total and an
// invalid range skip the walk; a query or conflicted map stops early at the first
// failing page. The page table is one RAM of MAX_PAGES entries with one write and one read
// port, and the walk goes through it one entry at a time. After reset, and after each write
// of 1 to configured while it reads 0, a clearing pass writes zero to every entry in turn; no
// request word is taken during it, configuration writes still are. A new request word is taken
// while an earlier response word waits for rsp_ready.
module page_backing_tracker_top #(
   parameter int MAX_PAGES = pbt_pkg::DEFAULT_MAX_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [63:0] req_range_address,
   input  logic [63:0] req_range_bytes,
   input  logic [63:0] req_owner_handle,
   input  logic        req_has_metadata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_answer,
   output logic [63:0] rsp_mapped_bytes,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import pbt_pkg::*;

   localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int EW = 66;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [63:0]   region_base_ff;
   logic [12:0]   region_pages_ff;
   logic [5:0]    page_shift_ff;
   logic          configured_ff;
   logic          clear_start;

   logic [2:0]    action_ff, action_in;
   logic [63:0]   handle_ff, handle_in;
   logic          meta_ff, meta_in;
   logic [1:0]    status_ff, status_in;
   logic          answer_ff, answer_in;
   logic [IW-1:0] page_ff, page_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] clear_idx_ff, clear_idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic          rsp_answer_ff;
   logic [63:0]   rsp_bytes_ff;
   logic          rsp_load;

   logic          accept;
   chk_status_type chk;
   logic [IW-1:0] chk_start;
   logic [CW-1:0] chk_count;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;
   logic          ent_mapped;
   logic          ent_meta;
   logic [63:0]   ent_handle;
   logic          last_page;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign clear_start = csr_write && (csr_index == CFG_CONFIGURED) && csr_wdata[0] &&
                        !configured_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff  <= 64'd0;
         region_pages_ff <= 13'd0;
         page_shift_ff   <= PAGE_SHIFT_RESET;
         configured_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CFG_REGION_BASE:  region_base_ff  <= csr_wdata;
            CFG_REGION_PAGES: region_pages_ff <= csr_wdata[12:0];
            CFG_PAGE_SHIFT:   page_shift_ff   <= csr_wdata[5:0];
            CFG_CONFIGURED:   configured_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   pbt_range_check #(.MAX_PAGES(MAX_PAGES)) u_check (
      .clock         (clock),
      .reset         (reset),
      .go            (accept),
      .overlap       (req_action == ACT_RELEASABLE),
      .range_address (req_range_address),
      .range_bytes   (req_range_bytes),
      .region_base   (region_base_ff),
      .region_pages  (region_pages_ff),
      .page_shift    (page_shift_ff),
      .configured    (configured_ff),
      .result        (chk),
      .start_page    (chk_start),
      .page_count    (chk_count)
   );

   // Page table entry: mapped, metadata, handle
   pbt_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES), .AW(IW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (page_ff),
      .rd_data (rd_data)
   );

   assign ent_mapped = rd_data[65];
   assign ent_meta   = rd_data[64];
   assign ent_handle = rd_data[63:0];
   assign last_page  = (remain_ff == CW'(1));

   // Write port: clearing pass or write-back of the walked page
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = page_ff;
      wr_data = '0;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clear_idx_ff;
      end else if (state_ff == S_EVAL) begin
         if (action_ff == ACT_MAP) begin
            wr_en   = !(ent_mapped && (handle_ff != 64'd0) && (ent_handle != handle_ff));
            wr_data = {1'b1, meta_ff, handle_ff};
         end else if (action_ff inside {ACT_UNMAP, ACT_RELEASE}) begin
            wr_en = 1'b1;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      handle_in    = handle_ff;
      meta_in      = meta_ff;
      status_in    = status_ff;
      answer_in    = answer_ff;
      page_in      = page_ff;
      remain_in    = remain_ff;
      count_in     = count_ff;
      clear_idx_in = clear_idx_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               handle_in = req_owner_handle;
               meta_in   = req_has_metadata;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (chk.valid) begin
               answer_in = 1'b0;
               status_in = ST_OK;
               if (action_ff == ACT_READ_TOTAL) begin
                  status_in = configured_ff ? ST_OK : ST_INVALID;
                  state_in  = S_FINISH;
               end else if (!chk.ok) begin
                  status_in = ST_INVALID;
                  state_in  = S_FINISH;
               end else begin
                  answer_in = (action_ff >= ACT_ALL_MAPPED);
                  page_in   = chk_start;
                  remain_in = chk_count;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // advance unless this page ends the walk
            state_in  = last_page ? S_FINISH : S_READ;
            page_in   = page_ff + IW'(1);
            remain_in = remain_ff - CW'(1);
            case (action_ff)
               ACT_MAP: begin
                  if (ent_mapped && (handle_ff != 64'd0) && (ent_handle != handle_ff)) begin
                     status_in = ST_CONFLICT;
                     state_in  = S_FINISH;
                  end else if (!ent_mapped) begin
                     count_in = count_ff + CW'(1);
                  end
               end
               ACT_UNMAP, ACT_RELEASE: begin
                  if (ent_mapped && (count_ff != '0)) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               ACT_ALL_MAPPED: begin
                  if (!ent_mapped) begin
                     answer_in = 1'b0;
                     state_in  = S_FINISH;
                  end
               end
               ACT_ALL_UNMAPPED: begin
                  if (ent_mapped) begin
                     answer_in = 1'b0;
                     state_in  = S_FINISH;
                  end
               end
               ACT_RELEASABLE: begin
                  if (!ent_mapped || !ent_meta) begin
                     answer_in = 1'b0;
                     state_in  = S_FINISH;
                  end
               end
               default: begin
                  if (!ent_mapped || (ent_handle != handle_ff)) begin
                     answer_in = 1'b0;
                     state_in  = S_FINISH;
                  end
               end
            endcase
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            clear_idx_in = clear_idx_ff + IW'(1);
            if (clear_idx_ff == IW'(MAX_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // configure edge restarts the clearing pass and drops the page count
      if (clear_start) begin
         state_in     = S_CLEAR;
         clear_idx_in = '0;
         count_in     = '0;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      handle_ff <= handle_in;
      meta_ff   <= meta_in;
      status_ff <= status_in;
      answer_ff <= answer_in;
      page_ff   <= page_in;
      remain_ff <= remain_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_answer_ff <= answer_ff;
         rsp_bytes_ff  <= 64'(count_ff) << page_shift_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_mapped_bytes = rsp_bytes_ff;

   // The mapped page count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_PAGES))
      else $error("mapped page count beyond table depth");

   // A configure edge always starts a clearing pass
   a_clear_on_configure: assert property (@(posedge clock) disable iff (reset)
      clear_start |=> (state_ff == S_CLEAR) && (clear_idx_ff == '0))
      else $error("configure edge did not start clearing pass");

   // A waiting response word is never overwritten
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && rsp_valid_ff && !rsp_ready && !clear_start
      |=> (state_ff == S_FINISH) && rsp_valid_ff)
      else $error("response word overwritten while pending");

endmodule
